>>> rtl/vector_distance_metric_core_defines.svh
// ---------------------------------------------------------------------------
// Vector distance metric core: assertion macros
// Shared assertion forms used by the checker of the distance core.
// ---------------------------------------------------------------------------
`ifndef VECTOR_DISTANCE_METRIC_CORE_DEFINES_SVH
`define VECTOR_DISTANCE_METRIC_CORE_DEFINES_SVH

// Checked only outside reset.
`define VDM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define VDM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/vdm_pkg.sv
// ---------------------------------------------------------------------------
// vdm_pkg
// Types and constants shared by the vector distance metric core.
// ---------------------------------------------------------------------------
`default_nettype none

package vdm_pkg;

  localparam int COORD_W      = 16;
  localparam int SQ_W         = 2 * COORD_W;
  localparam int SUMSQ_W      = SQ_W + 2;
  localparam int SUMABS_W     = COORD_W + 2;
  localparam int TOT_W        = 39;
  localparam int DIST_W       = 22;
  localparam int ROOT_W       = (TOT_W + 1) / 2;
  localparam int COORD_MAX    = 65535;
  localparam int FIELD_LANES  = 4;
  localparam int LANE_CNT_W   = 3;
  localparam int LANES_LSB    = 2 * FIELD_LANES * COORD_W;
  localparam int IN_TDATA_W   = 136;
  localparam int OUT_TDATA_W  = 24;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;
  localparam int MODE_W       = 2;

  // Register word index on the configuration port.
  localparam logic REG_METRIC_MODE = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_EUCLIDEAN = 2'd0,
    MODE_MANHATTAN = 2'd1,
    MODE_CHEBYSHEV = 2'd2,
    MODE_NONE      = 2'd3
  } metric_mode_t;

  typedef enum logic [3:0] {
    S_RUN   = 4'b0001,
    S_CLAMP = 4'b0010,
    S_ROOT  = 4'b0100,
    S_SEND  = 4'b1000
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] abs_diff;
    logic [SQ_W-1:0]    sq_diff;
  } lane_res_t;

  typedef struct packed {
    logic                valid;
    logic                last;
    logic [SUMSQ_W-1:0]  sum_sq;
    logic [SUMABS_W-1:0] sum_abs;
    logic [COORD_W-1:0]  max_abs;
  } merge_res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

`default_nettype wire

>>> rtl/vdm_lane.sv
// ---------------------------------------------------------------------------
// vdm_lane
// One coordinate lane: absolute difference and its square, registered.
// ---------------------------------------------------------------------------
`default_nettype none

module vdm_lane
  import vdm_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic               en,
  input  logic [COORD_W-1:0] coord_a,
  input  logic [COORD_W-1:0] coord_b,
  output lane_res_t          res
);

  logic [COORD_W-1:0] diff;
  logic [SQ_W-1:0]    sq;

  always_comb begin
    diff = (coord_a >= coord_b) ? (coord_a - coord_b) : (coord_b - coord_a);
    sq   = SQ_W'(diff) * SQ_W'(diff);
  end

  // An unused lane contributes zero to every metric.
  always_ff @(posedge clk) begin
    if (load) begin
      res.abs_diff <= en ? diff : '0;
      res.sq_diff  <= en ? sq : '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/vdm_merge.sv
// ---------------------------------------------------------------------------
// vdm_merge
// Combines the lane results of one beat into sum of squares, sum and maximum.
// ---------------------------------------------------------------------------
`default_nettype none

module vdm_merge
  import vdm_pkg::*;
#(
  parameter int LANES = 4
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_last,
  input  lane_res_t  lane_q [LANES],
  output merge_res_t res
);

  logic [SUMSQ_W-1:0]  sum_sq;
  logic [SUMABS_W-1:0] sum_abs;
  logic [COORD_W-1:0]  max_abs;

  always_comb begin
    sum_sq  = '0;
    sum_abs = '0;
    max_abs = '0;
    for (int i = 0; i < LANES; i++) begin
      sum_sq  = sum_sq + SUMSQ_W'(lane_q[i].sq_diff);
      sum_abs = sum_abs + SUMABS_W'(lane_q[i].abs_diff);
      if (lane_q[i].abs_diff > max_abs) begin
        max_abs = lane_q[i].abs_diff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      res.last    <= in_last;
      res.sum_sq  <= sum_sq;
      res.sum_abs <= sum_abs;
      res.max_abs <= max_abs;
    end
  end

endmodule

`default_nettype wire

>>> rtl/vdm_sqrt.sv
// ---------------------------------------------------------------------------
// vdm_sqrt
// Iterative floor square root, one result bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module vdm_sqrt
  import vdm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TOT_W-1:0]  radicand,
  output sqrt_stat_t        stat,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] rad;
  logic [ROOT_W+1:0]   rem;
  logic [ROOT_W+1:0]   rem_sh;
  logic [ROOT_W+1:0]   trial;
  logic [CNT_W-1:0]    cnt;
  logic                fits;

  // The partial remainder stays below 2^ROOT_W before the final step,
  // so its two top bits can be dropped when shifting in the next pair.
  always_comb begin
    rem_sh = {rem[ROOT_W-1:0], rad[2*ROOT_W-1 -: 2]};
    trial  = {root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CNT_W'(ROOT_W);
      end else if (stat.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= (2*ROOT_W)'(radicand);
      rem  <= '0;
      root <= '0;
    end else if (stat.busy) begin
      rad <= {rad[2*ROOT_W-3:0], 2'b00};
      if (fits) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/vector_distance_metric_core.sv
// ---------------------------------------------------------------------------
// vector_distance_metric_core
// Streaming L2 / L1 / L-infinity distance between two Q0.16 vectors.
// ---------------------------------------------------------------------------
// Each input beat carries up to four coordinate pairs; beats without tlast
// are taken one per cycle while the input is not stalled and are folded,
// through the lane and merge stages, into a saturating running total.
// After the beat with tlast the input stalls until the distance sits in
// the output register: the result passes the lane, merge, clamp and send
// steps, and for the Euclidean metric also the bit-serial square root
// unit, which produces one root bit per cycle. The next vector may start
// while the previous distance still waits on the output side. The metric
// is chosen by the metric_mode register at byte address 0. The user must
// write it only while the core is idle; the core does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

module vector_distance_metric_core
  import vdm_pkg::*;
#(
  parameter int LANES   = 4,
  parameter int MAX_DIM = 64
)
(
  input  logic                   clk,
  input  logic                   rst,
  // tdata: coord_a0..coord_a3, coord_b0..coord_b3 (16 bits each),
  //        lanes_used (3 bits), zero fill
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tlast,
  // tdata: distance (22 bits), zero fill
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam logic [TOT_W-1:0] LIM_EUCLIDEAN =
    TOT_W'(MAX_DIM) * TOT_W'(COORD_MAX) * TOT_W'(COORD_MAX);
  localparam logic [TOT_W-1:0] LIM_MANHATTAN = TOT_W'(MAX_DIM) * TOT_W'(COORD_MAX);
  localparam logic [TOT_W-1:0] LIM_CHEBYSHEV = TOT_W'(COORD_MAX);

  metric_mode_t        metric_mode;
  state_t              state;
  logic                closing;
  logic                accept;
  logic                s1_valid;
  logic                s1_last;
  logic                s1_any;
  logic                mrg_any;
  lane_res_t           lane_q [LANES];
  merge_res_t          mrg;
  logic [TOT_W-1:0]    total;
  logic [TOT_W-1:0]    total_next;
  logic [TOT_W:0]      add_sq;
  logic [TOT_W:0]      add_abs;
  logic [TOT_W-1:0]    limit;
  logic [TOT_W-1:0]    fin;
  logic [DIST_W-1:0]   dist_clamp;
  logic [DIST_W-1:0]   dist_out;
  logic                sqrt_start;
  sqrt_stat_t          sqrt_stat;
  logic [ROOT_W-1:0]   root;
  logic [LANE_CNT_W-1:0] lanes_used;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode <= MODE_EUCLIDEAN;
    end else if (psel && penable && pwrite && (paddr[2] == REG_METRIC_MODE)) begin
      metric_mode <= metric_mode_t'(pwdata[MODE_W-1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_METRIC_MODE) begin
      prdata = APB_DATA_W'(metric_mode);
    end
  end

  // Input side: blocked from the closing beat until its result is loaded.
  assign s_tready   = !closing;
  assign accept     = s_tvalid && s_tready;
  assign lanes_used = s_tdata[LANES_LSB +: LANE_CNT_W];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    vdm_lane u_lane (
      .clk     (clk),
      .load    (accept),
      .en      (LANE_CNT_W'(i) < lanes_used),
      .coord_a (s_tdata[COORD_W*i +: COORD_W]),
      .coord_b (s_tdata[COORD_W*(FIELD_LANES+i) +: COORD_W]),
      .res     (lane_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last <= s_tlast;
      s1_any  <= (lanes_used != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      mrg_any <= s1_any;
    end
  end

  vdm_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .in_last  (s1_last),
    .lane_q   (lane_q),
    .res      (mrg)
  );

  // Saturating accumulation under the current metric. A beat with no lanes
  // leaves the total exactly as it is.
  always_comb begin
    add_sq  = {1'b0, total} + (TOT_W+1)'(mrg.sum_sq);
    add_abs = {1'b0, total} + (TOT_W+1)'(mrg.sum_abs);
    case (metric_mode)
      MODE_EUCLIDEAN: begin
        limit      = LIM_EUCLIDEAN;
        total_next = (add_sq > {1'b0, LIM_EUCLIDEAN}) ? LIM_EUCLIDEAN
                                                      : add_sq[TOT_W-1:0];
      end
      MODE_MANHATTAN: begin
        limit      = LIM_MANHATTAN;
        total_next = (mrg_any && (add_abs > {1'b0, LIM_MANHATTAN})) ? LIM_MANHATTAN
                                                                    : add_abs[TOT_W-1:0];
      end
      MODE_CHEBYSHEV: begin
        limit      = LIM_CHEBYSHEV;
        total_next = (TOT_W'(mrg.max_abs) > total) ? TOT_W'(mrg.max_abs) : total;
      end
      default: begin
        limit      = '0;
        total_next = total;
      end
    endcase
  end

  assign sqrt_start = (state == S_CLAMP) && (metric_mode == MODE_EUCLIDEAN);
  assign dist_out   = (metric_mode == MODE_EUCLIDEAN) ? DIST_W'(root) : dist_clamp;

  vdm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (fin),
    .stat     (sqrt_stat),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RUN;
      closing  <= 1'b0;
      total    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_SEND)) begin
        m_tvalid <= 1'b0;
      end
      if (accept && s_tlast) begin
        closing <= 1'b1;
      end
      case (state)
        S_RUN: begin
          if (mrg.valid) begin
            total <= mrg.last ? '0 : total_next;
            if (mrg.last) begin
              state <= S_CLAMP;
            end
          end
        end
        S_CLAMP: begin
          state <= (metric_mode == MODE_EUCLIDEAN) ? S_ROOT : S_SEND;
        end
        S_ROOT: begin
          if (sqrt_stat.done) begin
            state <= S_SEND;
          end
        end
        S_SEND: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            closing  <= 1'b0;
            state    <= S_RUN;
          end
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

  // Final total is clamped to the limit of the metric in force at the end.
  always_ff @(posedge clk) begin
    if ((state == S_RUN) && mrg.valid && mrg.last) begin
      fin <= total_next;
    end else if (state == S_CLAMP) begin
      if (fin > limit) begin
        fin <= limit;
      end
      dist_clamp <= (fin > limit) ? limit[DIST_W-1:0] : fin[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_SEND) && (!m_tvalid || m_tready)) begin
      m_tdata <= OUT_TDATA_W'(dist_out);
    end
  end

endmodule

`default_nettype wire

>>> rtl/vdm_checker.sv
// ---------------------------------------------------------------------------
// vdm_checker
// Port-level checks of the distance core, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "vector_distance_metric_core_defines.svh"

module vdm_checker
  import vdm_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   s_tlast,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  `VDM_ASSERT_ALWAYS(a_no_result_after_reset, rst |=> !m_tvalid, "result shown after reset")

  `VDM_ASSERT(a_hold_result, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

  `VDM_ASSERT(a_stall_after_last, s_tvalid && s_tready && s_tlast |=> !s_tready, "input not stalled after closing beat")

  `VDM_ASSERT(a_release_with_result, $rose(s_tready) |-> m_tvalid, "input released without a result")

  `VDM_ASSERT(a_fill_zero, m_tvalid |-> (m_tdata[OUT_TDATA_W-1:DIST_W] == '0), "nonzero fill bits in result")

endmodule

bind vector_distance_metric_core vdm_checker u_vdm_checker (.*);

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: vector distance metric core bench
// Streams coordinate-pair beats into the core under every metric, keeps its
// own model of the running total to work out each expected distance, and
// checks every distance beat against the oldest pending one. Both stream
// sides idle at random, and the metric register is rewritten between phases.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
  import vdm_pkg::*;

  localparam int LANES   = 4;
  localparam int MAX_DIM = 64;
  localparam logic [APB_ADDR_W-1:0] MODE_ADDR = APB_ADDR_W'(4 * REG_METRIC_MODE);
  // Longest path from the last beat to the output register, with margin.
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic             last;
    logic [2:0]       lanes;
    logic [3:0][15:0] b;
    logic [3:0][15:0] a;
  } pair_beat_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // tdata: coord_a0..coord_a3, coord_b0..coord_b3 (16 bits each),
  //        lanes_used (3 bits), zero fill
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // tdata: distance (22 bits), zero fill
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  metric_mode_t      mode_now = MODE_EUCLIDEAN;
  logic [63:0]       total_now = '0;
  logic [DIST_W-1:0] pending_dist [$];
  int                errors = 0;
  int                beats_sent = 0;
  bit                no_idle = 1'b0;

  vector_distance_metric_core #(
    .LANES   (LANES),
    .MAX_DIM (MAX_DIM)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // ---- distance prediction ------------------------------------------------

  function automatic logic [63:0] mode_cap(metric_mode_t m);
    case (m)
      MODE_EUCLIDEAN: return 64'(MAX_DIM) * 64'(COORD_MAX) * 64'(COORD_MAX);
      MODE_MANHATTAN: return 64'(MAX_DIM) * 64'(COORD_MAX);
      MODE_CHEBYSHEV: return 64'(COORD_MAX);
      default:        return 64'd0;
    endcase
  endfunction

  // Binary search for the largest root whose square fits.
  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int k = 20; k >= 0; k--) begin
      trial = root | (64'd1 << k);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic void fold_coords(pair_beat_t bt);
    logic [63:0] cap;
    logic [63:0] d;
    logic [63:0] res;
    int          n;
    cap = mode_cap(mode_now);
    n = (bt.lanes > LANES) ? LANES : int'(bt.lanes);
    for (int i = 0; i < n; i++) begin
      d = (bt.a[i] >= bt.b[i]) ? 64'(bt.a[i]) - 64'(bt.b[i])
                               : 64'(bt.b[i]) - 64'(bt.a[i]);
      case (mode_now)
        MODE_EUCLIDEAN: begin
          total_now = total_now + d * d;
          if (total_now > cap) total_now = cap;
        end
        MODE_MANHATTAN: begin
          total_now = total_now + d;
          if (total_now > cap) total_now = cap;
        end
        MODE_CHEBYSHEV: begin
          if (d > total_now) total_now = d;
        end
        default: ;
      endcase
    end
    total_now = {25'd0, total_now[TOT_W-1:0]};
    if (bt.last) begin
      // The end of a vector is clamped to the limit of the mode then in force.
      res = (total_now > cap) ? cap : total_now;
      if (mode_now == MODE_EUCLIDEAN) res = root_floor(res);
      pending_dist.push_back(res[DIST_W-1:0]);
      total_now = '0;
    end
  endfunction

  // ---- stimulus helpers ---------------------------------------------------

  function automatic int pick_gap();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 15))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'hFFFE;
      3:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic pair_beat_t mk(logic [63:0] a, logic [63:0] b,
                                    logic [2:0] lanes, logic last);
    pair_beat_t bt;
    bt.a = a;
    bt.b = b;
    bt.lanes = lanes;
    bt.last = last;
    return bt;
  endfunction

  task automatic send_beat(input pair_beat_t bt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata = '0;
    s_tdata[2*FIELD_LANES*COORD_W-1:0] = {bt.b, bt.a};
    s_tdata[LANES_LSB +: LANE_CNT_W] = bt.lanes;
    s_tlast = bt.last;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    fold_coords(bt);
    beats_sent++;
    @(negedge clk);
  endtask

  // Holds the sender until every pending distance is out and the core is quiet.
  task automatic wait_for_results();
    s_tvalid = 1'b0;
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_metric(input metric_mode_t m);
    logic [APB_DATA_W-1:0] readback;
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = MODE_ADDR;
    pwdata = APB_DATA_W'(m);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    mode_now = m;
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (readback !== APB_DATA_W'(m)) report_mismatch("metric_mode readback", readback, m);
  endtask

  task automatic send_random_vector();
    pair_beat_t bt;
    bit         heavy;
    int         len;
    // Long vectors of mostly full-scale differences drive the total into saturation.
    heavy = ($urandom_range(0, 9) == 0);
    len = heavy ? $urandom_range(17, 24) : $urandom_range(1, 6);
    for (int k = 0; k < len; k++) begin
      for (int i = 0; i < 4; i++) begin
        if (heavy) begin
          bt.a[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          bt.b[i] = ($urandom_range(0, 7) != 0) ? ~bt.a[i] : pick_coord();
        end else begin
          bt.a[i] = pick_coord();
          bt.b[i] = pick_coord();
        end
      end
      if (heavy) bt.lanes = 3'd4;
      else if ($urandom_range(0, 7) == 0) bt.lanes = 3'($urandom_range(0, 7));
      else bt.lanes = 3'($urandom_range(1, 4));
      bt.last = (k == len - 1);
      send_beat(bt);
    end
  endtask

  // ---- result checking ----------------------------------------------------

  initial begin
    int                stall;
    logic [DIST_W-1:0] want;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = pick_gap();
      m_tready = 1'b0;
      repeat (stall) @(negedge clk);
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (pending_dist.size() == 0) begin
        report_mismatch("distance beat with none pending", m_tdata[DIST_W-1:0], 0);
      end else begin
        want = pending_dist.pop_front();
        if (m_tdata[DIST_W-1:0] !== want)
          report_mismatch("distance", m_tdata[DIST_W-1:0], want);
      end
      @(negedge clk);
    end
  end

  // ---- tests --------------------------------------------------------------

  task automatic test_extremes();
    set_metric(MODE_EUCLIDEAN);
    send_beat(mk({4{16'hFFFF}}, 64'd0, 3'd4, 1'b1));
    send_beat(mk(64'd0, {4{16'hFFFF}}, 3'd4, 1'b1));
    send_beat(mk({4{16'h1234}}, {4{16'h1234}}, 3'd4, 1'b1));
    // More lanes than exist are treated as all lanes.
    send_beat(mk(64'h0001_8000_FFFF_0000, 64'h0000_0000_0000_FFFF, 3'd7, 1'b1));
    // A beat with no lanes still closes the vector.
    send_beat(mk({4{16'hFFFF}}, 64'd0, 3'd0, 1'b1));
    send_beat(mk(64'h7FFF_0003_0002_0001, 64'h8000_FFFC_FFFD_FFFE, 3'd2, 1'b0));
    send_beat(mk(64'h0000_5555_AAAA_FFFF, 64'hFFFF_AAAA_5555_0000, 3'd3, 1'b1));
    wait_for_results();
  endtask

  task automatic test_metrics();
    metric_mode_t modes [3];
    modes[0] = MODE_MANHATTAN;
    modes[1] = MODE_CHEBYSHEV;
    modes[2] = MODE_NONE;
    foreach (modes[m]) begin
      set_metric(modes[m]);
      send_beat(mk(64'h0000_FFFF_8000_0001, 64'hFFFF_0000_0001_8000, 3'd4, 1'b0));
      send_beat(mk(64'h0100_0200_0300_0400, 64'h4000_0010_0001_2000, 3'd3, 1'b1));
      wait_for_results();
    end
  endtask

  task automatic test_saturation();
    set_metric(MODE_EUCLIDEAN);
    for (int k = 0; k < 17; k++)
      send_beat(mk({4{16'hFFFF}}, 64'd0, 3'd4, k == 16));
    wait_for_results();
  endtask

  // The metric changes while a vector is half way through.
  task automatic test_mode_switch();
    set_metric(MODE_EUCLIDEAN);
    send_beat(mk({4{16'hFFFF}}, 64'd0, 3'd4, 1'b0));
    send_beat(mk({4{16'hF000}}, 64'd0, 3'd4, 1'b0));
    wait_for_results();
    set_metric(MODE_CHEBYSHEV);
    send_beat(mk(64'd5, 64'd2, 3'd1, 1'b1));
    wait_for_results();
    set_metric(MODE_MANHATTAN);
    send_beat(mk({4{16'h8000}}, 64'd0, 3'd4, 1'b0));
    wait_for_results();
    set_metric(MODE_EUCLIDEAN);
    send_beat(mk(64'h0000_0000_0300_0400, 64'd0, 3'd2, 1'b1));
    wait_for_results();
  endtask

  task automatic test_random_phase(input metric_mode_t m, input int n_beats,
                                   input bit quiet);
    int start;
    set_metric(m);
    no_idle = quiet;
    start = beats_sent;
    while (beats_sent - start < n_beats) send_random_vector();
    wait_for_results();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    test_extremes();
    test_metrics();
    test_saturation();
    test_mode_switch();
    test_random_phase(MODE_EUCLIDEAN, 110, 1'b0);
    test_random_phase(MODE_MANHATTAN, 100, 1'b0);
    test_random_phase(MODE_CHEBYSHEV, 80, 1'b1);
    test_random_phase(MODE_NONE, 50, 1'b0);
    test_random_phase(MODE_EUCLIDEAN, 60, 1'b1);
    test_random_phase(metric_mode_t'($urandom_range(0, 3)), 100, 1'b0);
    wait_for_results();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
